[src/mtec_pkg.sv]
// shared constants, codes and helpers for the transfer encoding chooser
package mtec_pkg;

    // default sizes of the statistics counters
    localparam int DEF_COUNT_BITS = 32;
    localparam int DEF_LINE_BITS  = 16;

    // configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_COUNT_EN   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FORBID     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LF_CRLF    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TEXT       = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_LIMIT = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_QP_PCT     = 3'd6;

    // register widths and reset values
    localparam int LIMIT_BITS = 16;
    localparam int PCT_BITS   = 7;
    localparam logic [LIMIT_BITS-1:0] DEF_LINE_LIMIT = 16'd998;
    localparam logic [PCT_BITS-1:0]   DEF_QP_PCT     = 7'd17;
    localparam logic [PCT_BITS-1:0]   PCT_MAX        = 7'd100;

    // allowed output class
    localparam logic [1:0] LEVEL_7BIT   = 2'd0;
    localparam logic [1:0] LEVEL_8BIT   = 2'd1;
    localparam logic [1:0] LEVEL_BINARY = 2'd2;
    localparam logic [1:0] LEVEL_RSVD   = 2'd3;

    // transfer encodings
    localparam int ENC_BITS = 3;
    localparam logic [ENC_BITS-1:0] ENC_7BIT   = 3'd0;
    localparam logic [ENC_BITS-1:0] ENC_8BIT   = 3'd1;
    localparam logic [ENC_BITS-1:0] ENC_BINARY = 3'd2;
    localparam logic [ENC_BITS-1:0] ENC_QP     = 3'd3;
    localparam logic [ENC_BITS-1:0] ENC_BASE64 = 3'd4;

    // characters
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    // "From " matcher
    localparam int FROM_POS_BITS = 3;
    localparam logic [FROM_POS_BITS-1:0] FROM_LEN = 3'd5;

    // remainder of the byte count modulo one hundred
    localparam int REM_BITS = 7;
    localparam logic [REM_BITS-1:0] REM_LAST = 7'd99;

    // x / 100 for x below 2^14 as (x * RECIP_100) >> RECIP_SHIFT
    localparam int PROD_BITS   = 14;
    localparam int RECIP_BITS  = 13;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_BITS-1:0] RECIP_100 = 13'd5243;
    localparam int QUO_BITS = 8;

    // output field widths
    localparam int OUT_LEN_BITS   = 16;
    localparam int OUT_TOTAL_BITS = 32;

    function automatic logic [7:0] from_char(input logic [FROM_POS_BITS-1:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h46; // F
            3'd1:    ch = 8'h72; // r
            3'd2:    ch = 8'h6F; // o
            3'd3:    ch = 8'h6D; // m
            3'd4:    ch = 8'h20; // space
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[src/mime_transfer_encoding_chooser.sv]
// MIME transfer encoding chooser: byte statistics and encoding decision pipeline
//
// Takes one message word per clock while input ready is high (a byte, an end-of-message mark,
// or both) and keeps running statistics: top-bit bytes, NUL bytes, byte total, longest
// line, stray CR/LF and lines that begin with "From ". A word with end_of_message set
// closes the message: its statistics are captured into a three-stage decision pipeline
// (snapshot, products, limit) and the message state is cleared in the same cycle, so the
// next word may open a new message at once. Up to four closed messages can be held in the
// pipeline and output register; input ready drops only when all of them hold results not
// yet taken. The quoted-printable limit uses the byte total kept as quotient and remainder
// by one hundred, so no divider is needed. Counters saturate. Configuration writes are
// taken every cycle and are meant to happen only while the block is idle.
module mime_transfer_encoding_chooser #(
    parameter int COUNT_BITS = mtec_pkg::DEF_COUNT_BITS,
    parameter int LINE_BITS  = mtec_pkg::DEF_LINE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mtec_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [mtec_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    // message word channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_has_byte,
    input  logic                                i_end_of_message,
    // result word channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [mtec_pkg::ENC_BITS-1:0]       o_encoding,
    output logic [mtec_pkg::OUT_LEN_BITS-1:0]   o_max_line_len,
    output logic                                o_from_line_seen,
    output logic                                o_line_end_disorder,
    output logic [mtec_pkg::OUT_TOTAL_BITS-1:0] o_byte_total
);
    import mtec_pkg::*;

    localparam int Q_BITS   = COUNT_BITS - 6;
    localparam int QP_BITS  = Q_BITS + PCT_BITS;
    localparam int CMP_BITS = (LINE_BITS > LIMIT_BITS) ? LINE_BITS : LIMIT_BITS;
    localparam int TOT_BITS = (COUNT_BITS > OUT_TOTAL_BITS) ? COUNT_BITS : OUT_TOTAL_BITS;
    localparam int RD_BITS  = PROD_BITS + RECIP_BITS;

    // statistics that travel down the decision pipeline
    typedef struct packed {
        logic [COUNT_BITS-1:0]     hb;
        logic                      nul;
        logic                      from;
        logic                      dis;
        logic [OUT_TOTAL_BITS-1:0] total;
    } t_info;

    // configuration registers
    logic                  r_count_en, r_forbid, r_lf_crlf, r_text;
    logic [1:0]            r_level;
    logic [LIMIT_BITS-1:0] r_line_limit;
    logic [PCT_BITS-1:0]   r_pct;

    // message state
    logic [COUNT_BITS-1:0]    r_total, n_total;
    logic [Q_BITS-1:0]        r_quo, n_quo;
    logic [REM_BITS-1:0]      r_rem, n_rem;
    logic [COUNT_BITS-1:0]    r_hb, n_hb;
    logic                     r_nul, n_nul;
    logic                     r_dis, n_dis;
    logic                     r_from, n_from;
    logic [FROM_POS_BITS-1:0] r_pos, n_pos;
    logic                     r_act, n_act;
    logic [LINE_BITS-1:0]     r_len, n_len;
    logic [LINE_BITS-1:0]     r_longest, n_longest;
    logic                     r_prev_cr, n_prev_cr;
    logic [LINE_BITS-1:0]     fin_longest;
    logic [TOT_BITS-1:0]      total_ext;
    logic                     line_end;

    // pipeline
    logic                  r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    t_info                 r_s1_info, r_s2_info, r_s3_info;
    logic [Q_BITS-1:0]     r_s1_quo;
    logic [REM_BITS-1:0]   r_s1_rem;
    logic [LINE_BITS-1:0]  r_s1_longest;
    logic [CMP_BITS-1:0]   s1_longest_ext;
    logic [CMP_BITS-1:0]   s1_limit_ext;
    logic [QP_BITS-1:0]    s1_qp;
    logic [COUNT_BITS-1:0] r_s2_qp;
    logic [PROD_BITS-1:0]  r_s2_rp;
    logic [OUT_LEN_BITS-1:0] r_s2_len, r_s3_len;
    logic                  r_s2_long, r_s3_long;
    logic [RD_BITS-1:0]    s2_rd;
    logic [QUO_BITS-1:0]   s2_rdiv;
    logic [COUNT_BITS-1:0] r_s3_limit;
    logic [ENC_BITS-1:0]   s3_best, s3_enc;
    logic                  s3_qp_ok;

    // output register
    logic [ENC_BITS-1:0]       r_out_enc;
    logic [OUT_LEN_BITS-1:0]   r_out_len;
    logic                      r_out_from, r_out_dis;
    logic [OUT_TOTAL_BITS-1:0] r_out_total;

    logic in_acc, s1_rdy, s2_rdy, s3_rdy;

    // stage handshakes, each stage moves when its successor has room
    assign s3_rdy  = !r_out_valid || i_ready;
    assign s2_rdy  = !r_s3_valid || s3_rdy;
    assign s1_rdy  = !r_s2_valid || s2_rdy;
    assign o_ready = !r_s1_valid || s1_rdy;
    assign in_acc  = i_valid && o_ready;

    assign o_cfg_ready = 1'b1;

    // configuration writes, level and percent clamped on the way in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_en   <= 1'b1;
            r_forbid     <= 1'b0;
            r_lf_crlf    <= 1'b0;
            r_level      <= LEVEL_7BIT;
            r_text       <= 1'b1;
            r_line_limit <= DEF_LINE_LIMIT;
            r_pct        <= DEF_QP_PCT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COUNT_EN:   r_count_en <= i_cfg_data[0];
                CFG_FORBID:     r_forbid   <= i_cfg_data[0];
                CFG_LF_CRLF:    r_lf_crlf  <= i_cfg_data[0];
                CFG_LEVEL:      r_level    <= (i_cfg_data[1:0] == LEVEL_RSVD) ?
                                              LEVEL_BINARY : i_cfg_data[1:0];
                CFG_TEXT:       r_text     <= i_cfg_data[0];
                CFG_LINE_LIMIT: r_line_limit <= i_cfg_data[LIMIT_BITS-1:0];
                CFG_QP_PCT:     r_pct      <= (i_cfg_data[PCT_BITS-1:0] > PCT_MAX) ?
                                              PCT_MAX : i_cfg_data[PCT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // per-byte update of the message statistics
    always_comb begin
        n_total   = r_total;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_hb      = r_hb;
        n_nul     = r_nul;
        n_dis     = r_dis;
        n_from    = r_from;
        n_pos     = r_pos;
        n_act     = r_act;
        n_len     = r_len;
        n_longest = r_longest;
        n_prev_cr = r_prev_cr;
        line_end  = 1'b0;
        if (in_acc && i_has_byte) begin
            // total kept also as quotient and remainder by one hundred
            if (r_total != {COUNT_BITS{1'b1}}) begin
                n_total = r_total + 1'b1;
                if (r_rem == REM_LAST) begin
                    n_rem = '0;
                    n_quo = r_quo + 1'b1;
                end else begin
                    n_rem = r_rem + 1'b1;
                end
            end
            if (r_count_en) begin
                if (i_data_byte[7] && r_hb != {COUNT_BITS{1'b1}}) begin
                    n_hb = r_hb + 1'b1;
                end
                if (i_data_byte == CHAR_NUL) begin
                    n_nul = 1'b1;
                end
                if (i_data_byte == CHAR_CR && r_lf_crlf) begin
                    n_dis = 1'b1;
                end
                // "From " match at line start
                if (r_act) begin
                    if (r_forbid && !r_from && r_pos < FROM_LEN &&
                        i_data_byte == from_char(r_pos)) begin
                        n_pos = r_pos + 1'b1;
                        if (n_pos == FROM_LEN) begin
                            n_from = 1'b1;
                            n_act  = 1'b0;
                            n_pos  = '0;
                        end
                    end else begin
                        n_act = 1'b0;
                        n_pos = '0;
                    end
                end
                // line length and line ends
                if (i_data_byte == CHAR_LF) begin
                    if (r_prev_cr || r_lf_crlf) begin
                        line_end = 1'b1;
                    end else begin
                        n_dis = 1'b1;
                    end
                end else if (r_len != {LINE_BITS{1'b1}}) begin
                    n_len = r_len + 1'b1;
                end
                if (line_end) begin
                    if (r_len > r_longest) begin
                        n_longest = r_len;
                    end
                    n_len = '0;
                    n_act = 1'b1;
                    n_pos = '0;
                end
                n_prev_cr = (i_data_byte == CHAR_CR);
            end
        end
    end

    // the open line counts at end of message
    assign fin_longest = (n_len > n_longest) ? n_len : n_longest;
    assign total_ext   = TOT_BITS'(n_total);

    // message state, cleared when a message closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_acc && i_end_of_message)) begin
            r_total   <= '0;
            r_quo     <= '0;
            r_rem     <= '0;
            r_hb      <= '0;
            r_nul     <= 1'b0;
            r_dis     <= 1'b0;
            r_from    <= 1'b0;
            r_pos     <= '0;
            r_act     <= 1'b1;
            r_len     <= '0;
            r_longest <= '0;
            r_prev_cr <= 1'b0;
        end else begin
            r_total   <= n_total;
            r_quo     <= n_quo;
            r_rem     <= n_rem;
            r_hb      <= n_hb;
            r_nul     <= n_nul;
            r_dis     <= n_dis;
            r_from    <= n_from;
            r_pos     <= n_pos;
            r_act     <= n_act;
            r_len     <= n_len;
            r_longest <= n_longest;
            r_prev_cr <= n_prev_cr;
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= in_acc && i_end_of_message;
            end
            if (s1_rdy) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s2_rdy) begin
                r_s3_valid <= r_s2_valid;
            end
            if (s3_rdy) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    // stage 1: snapshot of the closed message
    always_ff @(posedge i_clk) begin
        if (in_acc && i_end_of_message) begin
            r_s1_info.hb    <= n_hb;
            r_s1_info.nul   <= n_nul;
            r_s1_info.from  <= n_from;
            r_s1_info.dis   <= n_dis;
            r_s1_info.total <= (total_ext > TOT_BITS'({OUT_TOTAL_BITS{1'b1}})) ?
                               {OUT_TOTAL_BITS{1'b1}} : total_ext[OUT_TOTAL_BITS-1:0];
            r_s1_quo        <= n_quo;
            r_s1_rem        <= n_rem;
            r_s1_longest    <= fin_longest;
        end
    end

    // stage 2: percent products, long line check, saturated line length
    assign s1_longest_ext = CMP_BITS'(r_s1_longest);
    assign s1_limit_ext   = CMP_BITS'(r_line_limit);
    assign s1_qp          = QP_BITS'(r_s1_quo) * QP_BITS'(r_pct);

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_rdy) begin
            r_s2_info <= r_s1_info;
            r_s2_qp   <= s1_qp[COUNT_BITS-1:0];
            r_s2_rp   <= PROD_BITS'(r_s1_rem) * PROD_BITS'(r_pct);
            r_s2_long <= s1_longest_ext >= s1_limit_ext;
            r_s2_len  <= (s1_longest_ext > CMP_BITS'({OUT_LEN_BITS{1'b1}})) ?
                         {OUT_LEN_BITS{1'b1}} : s1_longest_ext[OUT_LEN_BITS-1:0];
        end
    end

    // stage 3: quoted-printable limit, remainder part divided by one hundred
    assign s2_rd   = RD_BITS'(r_s2_rp) * RD_BITS'(RECIP_100);
    assign s2_rdiv = s2_rd[RECIP_SHIFT +: QUO_BITS];

    always_ff @(posedge i_clk) begin
        if (r_s2_valid && s2_rdy) begin
            r_s3_info  <= r_s2_info;
            r_s3_limit <= r_s2_qp + COUNT_BITS'(s2_rdiv);
            r_s3_long  <= r_s2_long;
            r_s3_len   <= r_s2_len;
        end
    end

    // decision
    assign s3_qp_ok = r_text && !r_s3_info.nul && (r_s3_info.hb < r_s3_limit);

    always_comb begin
        if (r_level == LEVEL_BINARY) begin
            s3_best = ENC_BINARY;
        end else if (s3_qp_ok) begin
            s3_best = ENC_QP;
        end else begin
            s3_best = ENC_BASE64;
        end
        if (r_forbid && r_s3_info.from) begin
            s3_enc = ENC_BASE64;
        end else if (r_s3_info.dis || r_s3_long) begin
            s3_enc = s3_best;
        end else if (r_s3_info.hb == '0 && !r_s3_info.nul) begin
            s3_enc = ENC_7BIT;
        end else if (r_level == LEVEL_7BIT || r_s3_info.nul) begin
            s3_enc = s3_best;
        end else begin
            s3_enc = ENC_8BIT;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_s3_valid && s3_rdy) begin
            r_out_enc   <= s3_enc;
            r_out_len   <= r_s3_len;
            r_out_from  <= r_s3_info.from;
            r_out_dis   <= r_s3_info.dis;
            r_out_total <= r_s3_info.total;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_encoding          = r_out_enc;
    assign o_max_line_len      = r_out_len;
    assign o_from_line_seen    = r_out_from;
    assign o_line_end_disorder = r_out_dis;
    assign o_byte_total        = r_out_total;

endmodule

[test/mtec_checker.sv]
// checker for the transfer encoding chooser: predicts each result word and compares it
module mtec_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // register writes
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [mtec_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [mtec_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    // message words
    input  logic                                i_valid,
    input  logic                                i_ready,
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_has_byte,
    input  logic                                i_end_of_message,
    // result words
    input  logic                                i_res_valid,
    input  logic                                i_res_ready,
    input  logic [mtec_pkg::ENC_BITS-1:0]       i_encoding,
    input  logic [mtec_pkg::OUT_LEN_BITS-1:0]   i_max_line_len,
    input  logic                                i_from_line_seen,
    input  logic                                i_line_end_disorder,
    input  logic [mtec_pkg::OUT_TOTAL_BITS-1:0] i_byte_total,
    // status for the top
    output int                                  o_errors,
    output int                                  o_pending,
    output int                                  o_checked
);
    import mtec_pkg::*;

    typedef struct packed {
        logic [ENC_BITS-1:0]       encoding;
        logic [OUT_LEN_BITS-1:0]   max_len;
        logic                      from_seen;
        logic                      disorder;
        logic [OUT_TOTAL_BITS-1:0] total;
    } t_mime_verdict;

    localparam logic [39:0] FROM_TEXT   = "From ";
    localparam int          MAX_PRINTED = 20;

    // register copies
    logic                  cfg_scan;
    logic                  cfg_forbid;
    logic                  cfg_lf;
    logic                  cfg_text;
    logic [1:0]            cfg_level;
    logic [LIMIT_BITS-1:0] cfg_limit;
    logic [PCT_BITS-1:0]   cfg_pct;

    // statistics of the open message
    logic [DEF_COUNT_BITS-1:0] high_cnt;
    logic [DEF_COUNT_BITS-1:0] nul_cnt;
    logic [DEF_COUNT_BITS-1:0] byte_cnt;
    logic [DEF_LINE_BITS-1:0]  cur_len;
    logic [DEF_LINE_BITS-1:0]  long_len;
    logic                      after_cr;
    logic                      disorder;
    logic                      from_hit;
    logic                      from_live;
    logic [FROM_POS_BITS-1:0]  from_pos;

    t_mime_verdict verdict_q[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

    task automatic report_fault(input string what, input longint unsigned got,
                                input longint unsigned want);
        o_errors++;
        if (o_errors <= MAX_PRINTED) begin
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        end
    endtask

    task automatic clear_message();
        high_cnt  = '0;
        nul_cnt   = '0;
        byte_cnt  = '0;
        cur_len   = '0;
        long_len  = '0;
        after_cr  = 1'b0;
        disorder  = 1'b0;
        from_hit  = 1'b0;
        from_live = 1'b1;
        from_pos  = '0;
    endtask

    task automatic reset_regs();
        cfg_scan   = 1'b1;
        cfg_forbid = 1'b0;
        cfg_lf     = 1'b0;
        cfg_level  = LEVEL_7BIT;
        cfg_text   = 1'b1;
        cfg_limit  = DEF_LINE_LIMIT;
        cfg_pct    = DEF_QP_PCT;
    endtask

    task automatic apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] d);
        case (idx)
            CFG_COUNT_EN:   cfg_scan   = d[0];
            CFG_FORBID:     cfg_forbid = d[0];
            CFG_LF_CRLF:    cfg_lf     = d[0];
            CFG_LEVEL:      cfg_level  = d[1:0];
            CFG_TEXT:       cfg_text   = d[0];
            CFG_LINE_LIMIT: cfg_limit  = d[LIMIT_BITS-1:0];
            CFG_QP_PCT:     cfg_pct    = d[PCT_BITS-1:0];
            default:        ;
        endcase
    endtask

    // statistics update for one message byte
    task automatic absorb_byte(input logic [7:0] c);
        logic       ends;
        logic [7:0] want_ch;
        ends    = 1'b0;
        want_ch = (from_pos < FROM_LEN) ? FROM_TEXT[8 * (4 - int'(from_pos)) +: 8] : 8'h00;
        if (c[7] && high_cnt != '1) high_cnt++;
        if (c == CHAR_NUL && nul_cnt != '1) nul_cnt++;
        if (c == CHAR_CR && cfg_lf) disorder = 1'b1;

        // "From " match at line start
        if (from_live) begin
            if (cfg_forbid && !from_hit && from_pos < FROM_LEN && c == want_ch) begin
                from_pos++;
                if (from_pos >= FROM_LEN) begin
                    from_hit  = 1'b1;
                    from_live = 1'b0;
                    from_pos  = '0;
                end
            end else begin
                from_live = 1'b0;
                from_pos  = '0;
            end
        end

        // line length and line ends
        if (c == CHAR_LF) begin
            if (after_cr || cfg_lf) ends = 1'b1;
            else disorder = 1'b1;
        end else if (cur_len != '1) begin
            cur_len++;
        end
        if (ends) begin
            if (cur_len > long_len) long_len = cur_len;
            cur_len   = '0;
            from_live = 1'b1;
            from_pos  = '0;
        end
        after_cr = (c == CHAR_CR);
    endtask

    // encoding decision for the closed message
    function automatic logic [ENC_BITS-1:0] choose_encoding();
        logic [1:0]          level;
        longint unsigned     pct;
        longint unsigned     total;
        longint unsigned     qp_limit;
        logic [ENC_BITS-1:0] best;
        level    = (cfg_level == LEVEL_RSVD) ? LEVEL_BINARY : cfg_level;
        pct      = (cfg_pct > PCT_MAX) ? 64'd100 : 64'(cfg_pct);
        total    = 64'(byte_cnt);
        qp_limit = total / 100 * pct + (total % 100) * pct / 100;

        if (cfg_forbid && from_hit) return ENC_BASE64;
        if (level == LEVEL_BINARY) best = ENC_BINARY;
        else if (cfg_text && nul_cnt == '0 && 64'(high_cnt) < qp_limit) best = ENC_QP;
        else best = ENC_BASE64;

        if (disorder || long_len >= cfg_limit) return best;
        if (high_cnt == '0 && nul_cnt == '0) return ENC_7BIT;
        if (level == LEVEL_7BIT) return best;
        return (nul_cnt == '0) ? ENC_8BIT : best;
    endfunction

    task automatic take_word(input logic [7:0] b, input logic h, input logic e);
        t_mime_verdict v;
        if (h) begin
            if (byte_cnt != '1) byte_cnt++;
            if (cfg_scan) absorb_byte(b);
        end
        if (e) begin
            if (cur_len > long_len) long_len = cur_len;
            cur_len     = '0;
            v.encoding  = choose_encoding();
            v.max_len   = long_len;
            v.from_seen = from_hit;
            v.disorder  = disorder;
            v.total     = byte_cnt;
            verdict_q.push_back(v);
            clear_message();
        end
    endtask

    task automatic check_result();
        t_mime_verdict want;
        if (verdict_q.size() == 0) begin
            report_fault("result word with nothing expected, encoding",
                         64'(i_encoding), 64'd0);
        end else begin
            want = verdict_q.pop_front();
            o_checked++;
            if (i_encoding != want.encoding)
                report_fault("encoding", 64'(i_encoding), 64'(want.encoding));
            if (i_max_line_len != want.max_len)
                report_fault("max_line_len", 64'(i_max_line_len), 64'(want.max_len));
            if (i_from_line_seen != want.from_seen)
                report_fault("from_line_seen", 64'(i_from_line_seen), 64'(want.from_seen));
            if (i_line_end_disorder != want.disorder)
                report_fault("line_end_disorder", 64'(i_line_end_disorder),
                             64'(want.disorder));
            if (i_byte_total != want.total)
                report_fault("byte_total", 64'(i_byte_total), 64'(want.total));
        end
    endtask

    // watch all three channels at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_regs();
            clear_message();
            verdict_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) apply_reg(i_cfg_index, i_cfg_data);
            if (i_res_valid && i_res_ready) check_result();
            if (i_valid && i_ready) take_word(i_data_byte, i_has_byte, i_end_of_message);
        end
        o_pending = verdict_q.size();
    end

endmodule

[test/mime_transfer_encoding_chooser_tb.sv]
// testbench top for the transfer encoding chooser: stimulus, stalls, watchdog and verdict
module mime_transfer_encoding_chooser_tb;
    import mtec_pkg::*;

    localparam int IDLE_LIMIT      = 4000;
    localparam int SETTLE          = 8;
    localparam int PHASE_WORDS     = 100;
    localparam int LONG_LINE_BYTES = 150;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 3'd7;

    // block inputs, known from the start
    logic                     i_clk            = 1'b0;
    logic                     i_rst_n          = 1'b0;
    logic                     i_cfg_valid      = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index      = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data       = '0;
    logic                     i_valid          = 1'b0;
    logic [7:0]               i_data_byte      = '0;
    logic                     i_has_byte       = 1'b0;
    logic                     i_end_of_message = 1'b0;
    logic                     i_ready          = 1'b0;

    // block outputs
    logic                      o_cfg_ready;
    logic                      o_ready;
    logic                      o_valid;
    logic [ENC_BITS-1:0]       o_encoding;
    logic [OUT_LEN_BITS-1:0]   o_max_line_len;
    logic                      o_from_line_seen;
    logic                      o_line_end_disorder;
    logic [OUT_TOTAL_BITS-1:0] o_byte_total;

    int errors;
    int pending;
    int checked;

    int    words_sent    = 0;
    int    settings_done = 0;
    int    burst_left    = 0;
    int    idle_cycles   = 0;
    bit    steady        = 1'b0;
    string from_text     = "From ";
    logic [7:0] msg_q[$];

    // receiver stall pattern state
    int rx_mode   = 0;
    int rx_left   = 0;
    int rx_period = 2;
    int rx_on     = 1;
    int rx_tick   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    mime_transfer_encoding_chooser dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_data_byte         (i_data_byte),
        .i_has_byte          (i_has_byte),
        .i_end_of_message    (i_end_of_message),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_encoding          (o_encoding),
        .o_max_line_len      (o_max_line_len),
        .o_from_line_seen    (o_from_line_seen),
        .o_line_end_disorder (o_line_end_disorder),
        .o_byte_total        (o_byte_total)
    );

    mtec_checker chk (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .i_ready             (o_ready),
        .i_data_byte         (i_data_byte),
        .i_has_byte          (i_has_byte),
        .i_end_of_message    (i_end_of_message),
        .i_res_valid         (o_valid),
        .i_res_ready         (i_ready),
        .i_encoding          (o_encoding),
        .i_max_line_len      (o_max_line_len),
        .i_from_line_seen    (o_from_line_seen),
        .i_line_end_disorder (o_line_end_disorder),
        .i_byte_total        (o_byte_total),
        .o_errors            (errors),
        .o_pending           (pending),
        .o_checked           (checked)
    );

    // result side stalls: always ready, mostly ready, mostly stalled, or periodic
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode   = $urandom_range(0, 3);
            rx_left   = $urandom_range(32, 256);
            rx_period = $urandom_range(2, 12);
            rx_on     = $urandom_range(1, rx_period - 1);
            rx_tick   = 0;
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            0:       i_ready <= 1'b1;
            1:       i_ready <= ($urandom_range(0, 3) != 0);
            2:       i_ready <= ($urandom_range(0, 3) == 0);
            default: i_ready <= ((rx_tick % rx_period) < rx_on);
        endcase
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("mime_transfer_encoding_chooser_tb: errors");
            $finish;
        end
    end

    // one message word, sent in bursts with random gaps
    task automatic put_word(input logic [7:0] b, input logic h, input logic e);
        int gap;
        if (burst_left == 0) begin
            gap = steady ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16));
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_valid          <= 1'b1;
        i_data_byte      <= b;
        i_has_byte       <= h;
        i_end_of_message <= e;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        burst_left--;
        if (h || e) words_sent++;
    endtask

    task automatic quiet_sender();
        i_valid    <= 1'b0;
        burst_left = 0;
    endtask

    // hold the sender until every expected result word is back
    task automatic drain();
        quiet_sender();
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // write every register while idle, with junk in the unused data bits
    task automatic set_config(input bit scan, input bit forbid, input bit lf,
                              input logic [1:0] level, input bit text,
                              input logic [LIMIT_BITS-1:0] limit,
                              input logic [PCT_BITS-1:0] pct);
        logic [CFG_DATA_BITS-1:0] d;
        drain();
        d = 16'($urandom); d[0] = scan;
        write_reg(CFG_COUNT_EN, d);
        d = 16'($urandom); d[0] = forbid;
        write_reg(CFG_FORBID, d);
        d = 16'($urandom); d[0] = lf;
        write_reg(CFG_LF_CRLF, d);
        d = 16'($urandom); d[1:0] = level;
        write_reg(CFG_LEVEL, d);
        d = 16'($urandom); d[0] = text;
        write_reg(CFG_TEXT, d);
        write_reg(CFG_LINE_LIMIT, limit);
        d = 16'($urandom); d[PCT_BITS-1:0] = pct;
        write_reg(CFG_QP_PCT, d);
        if (settings_done == 0) write_reg(CFG_UNUSED, 16'($urandom));
        i_cfg_valid <= 1'b0;
        settings_done++;
    endtask

    task automatic send_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++) begin
            put_word(s[i], 1'b1, close && (i == s.len() - 1));
        end
    endtask

    function automatic logic [7:0] pick_byte(input int hi_pct, input bit rough);
        int x;
        if ($urandom_range(0, 99) < hi_pct) return 8'h80 | 8'($urandom_range(0, 127));
        x = rough ? $urandom_range(0, 29) : 29;
        case (x)
            0:       return CHAR_NUL;
            1:       return CHAR_CR;
            2:       return CHAR_LF;
            3:       return 8'($urandom);
            default: return 8'($urandom_range(8'h20, 8'h7E));
        endcase
    endfunction

    // a message of a few lines: From heads, high-bit and NUL bytes, mixed line ends
    task automatic compose_message();
        int lines;
        int body;
        int hi_pct;
        int cut;
        bit rough;
        msg_q.delete();
        lines = $urandom_range(0, 4);
        rough = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 5))
            0, 1, 2: hi_pct = 0;
            3:       hi_pct = $urandom_range(1, 10);
            4:       hi_pct = $urandom_range(10, 40);
            default: hi_pct = 100;
        endcase
        for (int l = 0; l < lines; l++) begin
            // line head
            case ($urandom_range(0, 7))
                0, 1: begin
                    for (int i = 0; i < 5; i++) msg_q.push_back(from_text[i]);
                end
                2: begin
                    cut = $urandom_range(1, 4);
                    for (int i = 0; i < cut; i++) msg_q.push_back(from_text[i]);
                    msg_q.push_back(pick_byte(hi_pct, rough));
                end
                default: ;
            endcase
            // line body
            body = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 12);
            for (int k = 0; k < body; k++) msg_q.push_back(pick_byte(hi_pct, rough));
            // line end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    msg_q.push_back(CHAR_CR);
                    msg_q.push_back(CHAR_LF);
                end
                6, 7: msg_q.push_back(CHAR_LF);
                8: begin
                    msg_q.push_back(CHAR_CR);
                    msg_q.push_back(CHAR_CR);
                    msg_q.push_back(CHAR_LF);
                end
                default: ;
            endcase
        end
    endtask

    // close either on the last byte or with a word of its own
    task automatic send_message();
        int n;
        bit close_on_byte;
        n = msg_q.size();
        close_on_byte = ($urandom_range(0, 1) == 1);
        if (n == 0) begin
            put_word(8'($urandom), 1'b0, 1'b1);
        end else begin
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 19) == 0) put_word(8'($urandom), 1'b0, 1'b0);
                put_word(msg_q[i], 1'b1, close_on_byte && (i == n - 1));
            end
            if (!close_on_byte) put_word(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    task automatic run_phase(input int target);
        int start;
        start = words_sent;
        while (words_sent - start < target) begin
            steady = ($urandom_range(0, 5) == 0);
            compose_message();
            send_message();
            if ($urandom_range(0, 11) == 0) drain();
        end
        steady = 1'b0;
    endtask

    // one line that just reaches the line limit
    task automatic send_long_line();
        for (int i = 0; i < LONG_LINE_BYTES; i++) begin
            put_word(8'($urandom_range(8'h41, 8'h5A)), 1'b1, 1'b0);
        end
        put_word(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic random_config();
        logic [LIMIT_BITS-1:0] limit;
        case ($urandom_range(0, 3))
            0:       limit = 16'($urandom_range(1, 15));
            1:       limit = 16'($urandom_range(16, 80));
            2:       limit = DEF_LINE_LIMIT;
            default: limit = 16'($urandom);
        endcase
        set_config($urandom_range(0, 4) != 0, 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)), limit, 7'($urandom_range(0, 127)));
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words under the reset settings
        put_word(8'h5A, 1'b0, 1'b1);         // empty message
        put_word(8'hA5, 1'b0, 1'b0);         // empty word
        send_text("A", 1'b1);
        put_word(8'hFF, 1'b1, 1'b0);
        put_word(CHAR_NUL, 1'b1, 1'b0);
        put_word(8'h7F, 1'b0, 1'b1);
        put_word(CHAR_CR, 1'b1, 1'b0);
        put_word(CHAR_LF, 1'b1, 1'b0);
        put_word(8'h80, 1'b1, 1'b1);
        put_word(CHAR_LF, 1'b1, 1'b1);       // bare line feed
        put_word(CHAR_CR, 1'b1, 1'b0);       // stray carriage return
        put_word(8'h41, 1'b1, 1'b1);

        // from detection with line feed as line end
        set_config(1'b1, 1'b1, 1'b1, LEVEL_8BIT, 1'b1, 16'd4, PCT_MAX);
        send_text("From x", 1'b0);
        put_word(CHAR_LF, 1'b1, 1'b0);
        send_text("Fr", 1'b0);
        put_word(CHAR_CR, 1'b1, 1'b0);
        put_word(CHAR_LF, 1'b1, 1'b1);

        // fixed settings, extremes among them
        set_config(1'b1, 1'b1, 1'b0, LEVEL_7BIT, 1'b1, DEF_LINE_LIMIT, DEF_QP_PCT);
        run_phase(PHASE_WORDS);
        set_config(1'b1, 1'b1, 1'b1, LEVEL_8BIT, 1'b1, 16'd40, 7'd50);
        run_phase(PHASE_WORDS);
        set_config(1'b1, 1'b0, 1'b0, LEVEL_BINARY, 1'b0, 16'd10, 7'd0);
        run_phase(PHASE_WORDS);
        set_config(1'b0, 1'b1, 1'b1, LEVEL_7BIT, 1'b1, 16'd20, PCT_MAX);
        run_phase(PHASE_WORDS);
        set_config(1'b1, 1'b1, 1'b0, LEVEL_RSVD, 1'b1, 16'd0, 7'd127);
        run_phase(PHASE_WORDS);
        set_config(1'b1, 1'b0, 1'b1, LEVEL_8BIT, 1'b0, 16'(LONG_LINE_BYTES), 7'd5);
        send_long_line();
        run_phase(PHASE_WORDS / 2);

        // random settings
        for (int p = 0; p < 5; p++) begin
            random_config();
            run_phase(PHASE_WORDS);
        end

        // let the last result words come out
        quiet_sender();
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);

        $display("sent %0d message words, checked %0d result words", words_sent, checked);
        $display("%0d register settings incl. reserved level, zero limit, line at limit",
                 settings_done);
        if (errors == 0) begin
            $display("mime_transfer_encoding_chooser_tb: clean");
        end else begin
            $display("mime_transfer_encoding_chooser_tb: errors");
        end
        $finish;
    end

endmodule
